// ===== hdl/chained_hash_table_engine_defines.svh =====
// Assertion macros shared by the hash table engine.
`ifndef CHAINED_HASH_TABLE_ENGINE_DEFINES_SVH
`define CHAINED_HASH_TABLE_ENGINE_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define CHT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define CHT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/cht_pkg.sv =====
package cht_pkg;

  localparam int BUCKETS = 16;
  localparam int NODES   = 64;
  localparam int BKT_W   = $clog2(BUCKETS);
  localparam int NODE_W  = $clog2(NODES);
  localparam int LINK_W  = NODE_W + 1;
  localparam logic [LINK_W-1:0] EMPTY_LINK = '1;

  localparam int KEY_W  = 64;
  localparam int HASH_W = 32;
  localparam int VAL_W  = 64;
  localparam int IN_W   = 160;
  localparam int OUT_W  = 136;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_CLEAR  = 2'd2,
    MODE_LIST   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    accept;
    logic    rd;
    logic    ins_commit;
    logic    rm_unlink;
    logic    rm_step;
    logic    rm_free;
    logic    clear;
    logic    next_bucket;
    logic    l_take;
    logic    l_end;
    logic    emit_code;
    status_t code;
  } cht_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
    logic cur_valid;
    logic key_match;
    logic bk_last;
    logic have_pending;
  } cht_sts_t;

endpackage

// ===== hdl/cht_ram.sv =====
module cht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port that holds between reads.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/cht_ctrl.sv =====
module cht_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic [1:0]        in_mode,
  output logic              in_tready,
  input  cht_pkg::cht_sts_t sts,
  output cht_pkg::cht_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_INS_CHK, S_INS_CMT, S_FULL, S_RM_CHK, S_RM_CMP, S_RM_FREE,
    S_NF, S_CLR, S_L_NODE, S_L_DATA, S_L_END
  } state_t;

  state_t state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  // Next state and command decode.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.code  = cht_pkg::ST_OK;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          unique case (cht_pkg::mode_t'(in_mode))
            cht_pkg::MODE_INSERT: state_nxt = S_INS_CHK;
            cht_pkg::MODE_REMOVE: state_nxt = S_RM_CHK;
            cht_pkg::MODE_CLEAR:  state_nxt = S_CLR;
            default:              state_nxt = S_L_NODE;
          endcase
        end
      end
      S_INS_CHK: begin
        if (sts.cur_valid) begin
          cmd.rd    = 1'b1;
          state_nxt = S_INS_CMT;
        end else begin
          state_nxt = S_FULL;
        end
      end
      S_INS_CMT: begin
        if (sts.out_free) begin
          cmd.ins_commit = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      S_FULL: begin
        if (sts.out_free) begin
          cmd.emit_code = 1'b1;
          cmd.code      = cht_pkg::ST_FULL;
          state_nxt     = S_IDLE;
        end
      end
      S_RM_CHK: begin
        if (sts.cur_valid) begin
          cmd.rd    = 1'b1;
          state_nxt = S_RM_CMP;
        end else begin
          state_nxt = S_NF;
        end
      end
      S_RM_CMP: begin
        if (sts.key_match) begin
          cmd.rm_unlink = 1'b1;
          state_nxt     = S_RM_FREE;
        end else begin
          cmd.rm_step = 1'b1;
          state_nxt   = S_RM_CHK;
        end
      end
      S_RM_FREE: begin
        if (sts.out_free) begin
          cmd.rm_free = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      S_NF: begin
        if (sts.out_free) begin
          cmd.emit_code = 1'b1;
          cmd.code      = cht_pkg::ST_NOT_FOUND;
          state_nxt     = S_IDLE;
        end
      end
      S_CLR: begin
        if (sts.out_free) begin
          cmd.clear     = 1'b1;
          cmd.emit_code = 1'b1;
          cmd.code      = cht_pkg::ST_OK;
          state_nxt     = S_IDLE;
        end
      end
      S_L_NODE: begin
        if (sts.cur_valid) begin
          cmd.rd    = 1'b1;
          state_nxt = S_L_DATA;
        end else if (sts.bk_last) begin
          state_nxt = S_L_END;
        end else begin
          cmd.next_bucket = 1'b1;
        end
      end
      S_L_DATA: begin
        if (!sts.have_pending || sts.out_free) begin
          cmd.l_take = 1'b1;
          state_nxt  = S_L_NODE;
        end
      end
      S_L_END: begin
        if (sts.out_free) begin
          if (sts.have_pending) begin
            cmd.l_end = 1'b1;
          end else begin
            cmd.emit_code = 1'b1;
            cmd.code      = cht_pkg::ST_EMPTY;
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== hdl/cht_datapath.sv =====
module cht_datapath (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [1:0]                  in_mode,
  input  logic [cht_pkg::IN_W-1:0]    in_data,
  input  cht_pkg::cht_cmd_t           cmd,
  output cht_pkg::cht_sts_t           sts,
  input  logic                        out_tready,
  output logic                        out_tvalid,
  output logic [cht_pkg::OUT_W-1:0]   out_tdata,
  output logic [1:0]                  out_tuser,
  output logic                        out_tlast
);

  localparam int NW = cht_pkg::NODE_W;
  localparam int LW = cht_pkg::LINK_W;
  localparam int KW = cht_pkg::KEY_W;
  localparam int VW = cht_pkg::VAL_W;

  // Table state held in flip-flops.
  logic [LW-1:0]               heads_r [cht_pkg::BUCKETS];
  logic [cht_pkg::NODES-1:0]   nvalid_r;
  logic [LW-1:0]               free_head_r;

  // Item and walk registers.
  logic [KW-1:0]               key_r;
  logic [VW-1:0]               value_r;
  logic [cht_pkg::BKT_W-1:0]   bkt_r;
  logic [cht_pkg::BKT_W-1:0]   bk_r;
  logic [LW-1:0]               cur_r;
  logic [LW-1:0]               prev_r;

  // Pending list entry, held until the next one is known.
  logic                        have_pend_r;
  logic [NW-1:0]               pend_idx_r;
  logic [KW-1:0]               pend_key_r;
  logic [VW-1:0]               pend_val_r;

  // Output register.
  logic                        out_valid_r;
  logic [1:0]                  out_status_r;
  logic [NW-1:0]               out_idx_r;
  logic [KW-1:0]               out_key_r;
  logic [VW-1:0]               out_val_r;
  logic                        out_last_r;

  // Read side of the link memory.
  logic [NW-1:0]               rd_addr_r;
  logic                        rd_vld_r;
  logic [LW-1:0]               next_q;
  logic [LW-1:0]               next_eff;
  logic [KW+VW-1:0]            kv_q;

  logic                        nx_we;
  logic [NW-1:0]               nx_waddr;
  logic [LW-1:0]               nx_wdata;
  logic [NW-1:0]               cur_idx;
  logic [NW-1:0]               prev_idx;
  logic [cht_pkg::BKT_W-1:0]   in_bkt;
  logic [LW-1:0]               head_sel;
  logic                        out_load;

  assign cur_idx  = cur_r[NW-1:0];
  assign prev_idx = prev_r[NW-1:0];
  assign in_bkt   = in_data[KW +: cht_pkg::BKT_W];
  assign head_sel = heads_r[bkt_r];

  // A link entry never written still holds its reset value.
  always_comb begin
    if (rd_vld_r) begin
      next_eff = next_q;
    end else if (rd_addr_r == NW'(cht_pkg::NODES - 1)) begin
      next_eff = cht_pkg::EMPTY_LINK;
    end else begin
      next_eff = LW'(rd_addr_r) + LW'(1);
    end
  end

  // Link memory write port.
  always_comb begin
    nx_we    = 1'b0;
    nx_waddr = cur_idx;
    nx_wdata = head_sel;
    if (cmd.ins_commit) begin
      nx_we = 1'b1;
    end else if (cmd.rm_unlink && (prev_r < LW'(cht_pkg::NODES))) begin
      nx_we    = 1'b1;
      nx_waddr = prev_idx;
      nx_wdata = next_eff;
    end else if (cmd.rm_free) begin
      nx_we    = 1'b1;
      nx_wdata = free_head_r;
    end
  end

  cht_ram #(.WIDTH(LW), .DEPTH(cht_pkg::NODES)) u_next_ram (
    .clk   (clk),
    .we    (nx_we),
    .waddr (nx_waddr),
    .wdata (nx_wdata),
    .re    (cmd.rd),
    .raddr (cur_idx),
    .rdata (next_q)
  );

  cht_ram #(.WIDTH(KW + VW), .DEPTH(cht_pkg::NODES)) u_kv_ram (
    .clk   (clk),
    .we    (cmd.ins_commit),
    .waddr (cur_idx),
    .wdata ({value_r, key_r}),
    .re    (cmd.rd),
    .raddr (cur_idx),
    .rdata (kv_q)
  );

  assign sts.out_free     = !out_valid_r || out_tready;
  assign sts.cur_valid    = (cur_r < LW'(cht_pkg::NODES));
  assign sts.key_match    = (kv_q[KW-1:0] == key_r);
  assign sts.bk_last      = (bk_r == cht_pkg::BKT_W'(cht_pkg::BUCKETS - 1));
  assign sts.have_pending = have_pend_r;

  assign out_load = cmd.ins_commit || cmd.rm_free || cmd.emit_code || cmd.l_end
                    || (cmd.l_take && have_pend_r);

  // Table control state.
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      for (int i = 0; i < cht_pkg::BUCKETS; i++) begin
        heads_r[i] <= cht_pkg::EMPTY_LINK;
      end
      nvalid_r    <= '0;
      free_head_r <= '0;
    end else begin
      if (cmd.ins_commit) begin
        heads_r[bkt_r]    <= cur_r;
        nvalid_r[cur_idx] <= 1'b1;
        free_head_r       <= next_eff;
      end
      if (cmd.rm_unlink) begin
        if (prev_r < LW'(cht_pkg::NODES)) begin
          nvalid_r[prev_idx] <= 1'b1;
        end else begin
          heads_r[bkt_r] <= next_eff;
        end
      end
      if (cmd.rm_free) begin
        nvalid_r[cur_idx] <= 1'b1;
        free_head_r       <= cur_r;
      end
    end
  end

  // Walk registers.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      key_r   <= in_data[KW-1:0];
      value_r <= in_data[KW + cht_pkg::HASH_W +: VW];
      bkt_r   <= in_bkt;
      bk_r    <= '0;
      prev_r  <= cht_pkg::EMPTY_LINK;
      unique case (cht_pkg::mode_t'(in_mode))
        cht_pkg::MODE_INSERT: cur_r <= free_head_r;
        cht_pkg::MODE_REMOVE: cur_r <= heads_r[in_bkt];
        default:              cur_r <= heads_r[0];
      endcase
    end else if (cmd.rm_step || cmd.l_take) begin
      prev_r <= cur_r;
      cur_r  <= next_eff;
    end else if (cmd.next_bucket) begin
      bk_r  <= bk_r + 1'b1;
      cur_r <= heads_r[bk_r + 1'b1];
    end
    if (cmd.rd) begin
      rd_addr_r <= cur_idx;
      rd_vld_r  <= nvalid_r[cur_idx];
    end
  end

  // Pending list entry.
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.accept) begin
      have_pend_r <= 1'b0;
    end else if (cmd.l_take) begin
      have_pend_r <= 1'b1;
    end
    if (cmd.l_take) begin
      pend_idx_r <= cur_idx;
      pend_key_r <= kv_q[KW-1:0];
      pend_val_r <= kv_q[KW +: VW];
    end
  end

  // Output register: one result beat waits here while work goes on.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (out_load) begin
      out_key_r <= '0;
      out_val_r <= '0;
      out_idx_r <= '0;
      if (cmd.emit_code) begin
        out_status_r <= cmd.code;
        out_last_r   <= 1'b1;
      end else if (cmd.l_take || cmd.l_end) begin
        out_status_r <= cht_pkg::ST_OK;
        out_idx_r    <= pend_idx_r;
        out_key_r    <= pend_key_r;
        out_val_r    <= pend_val_r;
        out_last_r   <= cmd.l_end;
      end else begin
        out_status_r <= cht_pkg::ST_OK;
        out_idx_r    <= cur_idx;
        out_last_r   <= 1'b1;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {(cht_pkg::OUT_W - NW - KW - VW)'(0), out_val_r, out_key_r, out_idx_r};

endmodule

// ===== hdl/chained_hash_table_engine.sv =====
// Insert goes through a free-node check and a commit state, clear through a clear state.
// Remove visits the chain node by node, with one link memory read and key compare each.
// List reads entry by entry, stepping bucket by bucket; one input at a time.
// The output register lets the next input be taken while a result waits.
// rst_n is synchronous, active low: all chains empty, every node free.
// Clear restores that state directly; there is no clearing pass.
`include "chained_hash_table_engine_defines.svh"

module chained_hash_table_engine (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [cht_pkg::IN_W-1:0]    in_tdata,   // key[63:0], key_hash[95:64], value[159:96]
  input  logic [1:0]                  in_tuser,   // mode[1:0]
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [cht_pkg::OUT_W-1:0]   out_tdata,  // node_index[5:0], entry_key[69:6],
                                                  // entry_value[133:70], zero pad
  output logic [1:0]                  out_tuser,  // status[1:0]
  output logic                        out_tlast
);

  cht_pkg::cht_cmd_t cmd;
  cht_pkg::cht_sts_t sts;

  cht_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_mode   (in_tuser),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  cht_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mode    (in_tuser),
    .in_data    (in_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // The block works on one item at a time.
  `CHT_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready, "ready after accept")
  // Status results other than ok carry no node.
  `CHT_ASSERT_NOW(a_err_no_node, out_tvalid && (out_tuser != cht_pkg::ST_OK), out_tdata[5:0] == 6'd0, "error node")
  // An empty-table result ends the list.
  `CHT_ASSERT_NOW(a_empty_last, out_tvalid && (out_tuser == cht_pkg::ST_EMPTY), out_tlast, "empty not last")

endmodule

// ===== tb/sv/chained_hash_table_engine_tb.sv =====
`timescale 1ns / 100ps

module chained_hash_table_engine_tb;

  localparam int NODE_CNT = 64;
  localparam int BKT_CNT  = 16;
  localparam logic [6:0] NO_LINK = 7'd127;

  typedef struct packed {
    cht_pkg::mode_t mode;
    logic [63:0]    key;
    logic [31:0]    key_hash;
    logic [63:0]    value;
  } cmd_beat_t;

  typedef struct packed {
    cht_pkg::status_t status;
    logic [5:0]       node_index;
    logic [63:0]      entry_key;
    logic [63:0]      entry_value;
    logic             last;
  } table_resp_t;

  logic                      clk;
  logic                      rst_n;
  logic                      in_tvalid;
  logic                      in_tready;
  logic [cht_pkg::IN_W-1:0]  in_tdata;
  logic [1:0]                in_tuser;
  logic                      out_tvalid;
  logic                      out_tready;
  logic [cht_pkg::OUT_W-1:0] out_tdata;
  logic [1:0]                out_tuser;
  logic                      out_tlast;

  chained_hash_table_engine i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // Shadow copy of the table.
  logic [6:0]  shadow_heads [BKT_CNT];
  logic [6:0]  shadow_next [NODE_CNT];
  logic [63:0] shadow_keys [NODE_CNT];
  logic [63:0] shadow_vals [NODE_CNT];
  logic [6:0]  shadow_free;
  int          live_count;
  logic [63:0] live_keys [$];
  logic [31:0] live_hashes [$];

  cmd_beat_t   pending_cmds [$];
  table_resp_t expected_resps [$];
  int          fail_count;
  int          beats_checked;
  int          lists_seen;
  int          full_seen;
  int          missing_seen;
  int          send_idle_pct;
  int          recv_idle_pct;
  int          hold_cycles;
  bit          hold_request;
  bit          in_fire;

  // Clock with an 8 ns period.
  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  function automatic table_resp_t mk_resp(cht_pkg::status_t st, logic [5:0] idx,
                                          logic [63:0] k, logic [63:0] v, logic lst);
    table_resp_t r;
    r.status = st;
    r.node_index = idx;
    r.entry_key = k;
    r.entry_value = v;
    r.last = lst;
    return r;
  endfunction

  task automatic wipe_table();
    for (int i = 0; i < BKT_CNT; i++) shadow_heads[i] = NO_LINK;
    for (int i = 0; i < NODE_CNT; i++) begin
      shadow_next[i] = (i + 1 < NODE_CNT) ? 7'(i + 1) : NO_LINK;
      shadow_keys[i] = '0;
      shadow_vals[i] = '0;
    end
    shadow_free = '0;
    live_count = 0;
  endtask

  // Apply one accepted command to the shadow table and queue its results.
  task automatic predict_table_op(cmd_beat_t c);
    logic [3:0] b;
    logic [6:0] cur;
    logic [6:0] prev;
    int k;
    bit hit;
    b = c.key_hash[3:0];
    hit = 0;
    case (c.mode)
      cht_pkg::MODE_INSERT: begin
        cur = shadow_free;
        if (cur >= NODE_CNT) begin
          full_seen++;
          expected_resps.push_back(mk_resp(cht_pkg::ST_FULL, '0, '0, '0, 1'b1));
        end else begin
          shadow_free = shadow_next[cur];
          shadow_next[cur] = shadow_heads[b];
          shadow_keys[cur] = c.key;
          shadow_vals[cur] = c.value;
          shadow_heads[b] = cur;
          live_count++;
          expected_resps.push_back(mk_resp(cht_pkg::ST_OK, cur[5:0], '0, '0, 1'b1));
        end
      end
      cht_pkg::MODE_REMOVE: begin
        cur = shadow_heads[b];
        prev = NO_LINK;
        for (int s = 0; s < NODE_CNT && cur < NODE_CNT && !hit; s++) begin
          if (shadow_keys[cur] == c.key) begin
            hit = 1;
            if (prev < NODE_CNT) shadow_next[prev] = shadow_next[cur];
            else shadow_heads[b] = shadow_next[cur];
            shadow_keys[cur] = '0;
            shadow_vals[cur] = '0;
            shadow_next[cur] = shadow_free;
            shadow_free = cur;
            live_count--;
            expected_resps.push_back(mk_resp(cht_pkg::ST_OK, cur[5:0], '0, '0, 1'b1));
          end else begin
            prev = cur;
            cur = shadow_next[cur];
          end
        end
        if (!hit) begin
          missing_seen++;
          expected_resps.push_back(mk_resp(cht_pkg::ST_NOT_FOUND, '0, '0, '0, 1'b1));
        end
      end
      cht_pkg::MODE_CLEAR: begin
        wipe_table();
        expected_resps.push_back(mk_resp(cht_pkg::ST_OK, '0, '0, '0, 1'b1));
      end
      default: begin
        k = 0;
        lists_seen++;
        for (int bk = 0; bk < BKT_CNT; bk++) begin
          cur = shadow_heads[bk];
          for (int s = 0; s < NODE_CNT && cur < NODE_CNT && k < NODE_CNT; s++) begin
            expected_resps.push_back(mk_resp(cht_pkg::ST_OK, cur[5:0], shadow_keys[cur],
                                             shadow_vals[cur], 1'b0));
            k++;
            cur = shadow_next[cur];
          end
        end
        if (k == 0) expected_resps.push_back(mk_resp(cht_pkg::ST_EMPTY, '0, '0, '0, 1'b1));
        else expected_resps[$].last = 1'b1;
      end
    endcase
  endtask

  // Generator-side bookkeeping of live keys so removes mostly hit.
  task automatic queue_cmd(cht_pkg::mode_t m, logic [63:0] k, logic [31:0] h,
                           logic [63:0] v);
    cmd_beat_t c;
    c.mode = m;
    c.key = k;
    c.key_hash = h;
    c.value = v;
    pending_cmds.push_back(c);
    if (m == cht_pkg::MODE_INSERT && live_keys.size() < NODE_CNT) begin
      live_keys.push_back(k);
      live_hashes.push_back(h);
    end else if (m == cht_pkg::MODE_CLEAR) begin
      live_keys.delete();
      live_hashes.delete();
    end
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic queue_random(int n, int fill_pct);
    int pick;
    int j;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < fill_pct) begin
        // Small key space in some inserts gives duplicate keys.
        queue_cmd(cht_pkg::MODE_INSERT,
                  ($urandom_range(3) == 0) ? 64'($urandom_range(7)) : rand64(),
                  ($urandom_range(1) == 0) ? 32'($urandom_range(3)) : $urandom, rand64());
      end else if (pick < 85 && live_keys.size() > 0) begin
        j = $urandom_range(live_keys.size() - 1);
        queue_cmd(cht_pkg::MODE_REMOVE, live_keys[j],
                  live_hashes[j] ^ {28'($urandom_range(15)), 4'h0}, rand64());
        live_keys.delete(j);
        live_hashes.delete(j);
      end else if (pick < 88) begin
        queue_cmd(cht_pkg::MODE_REMOVE, rand64(), $urandom, rand64());
      end else if (pick < 97) begin
        queue_cmd(cht_pkg::MODE_LIST, rand64(), $urandom, rand64());
      end else begin
        queue_cmd(cht_pkg::MODE_CLEAR, rand64(), $urandom, rand64());
      end
    end
  endtask

  // Driver: offers queued commands, changes at the falling edge.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_fire) begin
      if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_tvalid <= 1'b1;
        in_tuser <= pending_cmds[0].mode;
        in_tdata <= {pending_cmds[0].value, pending_cmds[0].key_hash, pending_cmds[0].key};
        void'(pending_cmds.pop_front());
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Prediction runs on each accepted input beat.
  always @(posedge clk) begin
    in_fire <= rst_n && in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready) begin
      cmd_beat_t c;
      c.mode = cht_pkg::mode_t'(in_tuser);
      c.key = in_tdata[63:0];
      c.key_hash = in_tdata[95:64];
      c.value = in_tdata[159:96];
      predict_table_op(c);
    end
  end

  // Receiver back-pressure, with an optional long hold-off.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_cycles <= 0;
    end else if (hold_request && hold_cycles < 400) begin
      hold_cycles <= hold_cycles + 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor: compares each result beat with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      table_resp_t got;
      table_resp_t want;
      got = mk_resp(cht_pkg::status_t'(out_tuser), out_tdata[5:0], out_tdata[69:6],
                    out_tdata[133:70], out_tlast);
      beats_checked++;
      if (expected_resps.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected result beat %h", $time, got);
      end else begin
        want = expected_resps.pop_front();
        if (got.status !== want.status) begin
          fail_count++;
          $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
        end
        if (got.node_index !== want.node_index) begin
          fail_count++;
          $display("%0t: node_index expected %0d actual %0d", $time, want.node_index,
                   got.node_index);
        end
        if (got.entry_key !== want.entry_key) begin
          fail_count++;
          $display("%0t: entry_key expected %h actual %h", $time, want.entry_key,
                   got.entry_key);
        end
        if (got.entry_value !== want.entry_value) begin
          fail_count++;
          $display("%0t: entry_value expected %h actual %h", $time, want.entry_value,
                   got.entry_value);
        end
        if (got.last !== want.last) begin
          fail_count++;
          $display("%0t: last expected %0b actual %0b", $time, want.last, got.last);
        end
      end
    end
  end

  task automatic drain(int budget);
    int w;
    w = 0;
    while ((pending_cmds.size() > 0 || in_tvalid || expected_resps.size() > 0) && w < budget) begin
      @(posedge clk);
      w++;
    end
  endtask

  // Stimulus and sequencing.
  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    out_tready = 1'b0;
    fail_count = 0;
    beats_checked = 0;
    lists_seen = 0;
    full_seen = 0;
    missing_seen = 0;
    hold_request = 0;
    send_idle_pct = 7;
    recv_idle_pct = 83;
    wipe_table();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty list, missing key, field extremes, chain order, clear.
    queue_cmd(cht_pkg::MODE_LIST, '1, '1, '1);
    queue_cmd(cht_pkg::MODE_REMOVE, '1, '1, '0);
    queue_cmd(cht_pkg::MODE_INSERT, '0, '0, 64'h8000_0000_0000_0000);
    queue_cmd(cht_pkg::MODE_INSERT, '1, '1, 64'h7FFF_FFFF_FFFF_FFFF);
    queue_cmd(cht_pkg::MODE_INSERT, 64'h5, 32'h10, '1);
    queue_cmd(cht_pkg::MODE_INSERT, 64'h5, 32'h20, 64'h1);
    queue_cmd(cht_pkg::MODE_INSERT, 64'h6, 32'h0, 64'h2);
    queue_cmd(cht_pkg::MODE_LIST, '0, '0, '0);
    queue_cmd(cht_pkg::MODE_REMOVE, 64'h5, 32'h0, '0);
    queue_cmd(cht_pkg::MODE_REMOVE, 64'h0, 32'hF0, '0);
    queue_cmd(cht_pkg::MODE_REMOVE, '1, 32'h0, '0);
    queue_cmd(cht_pkg::MODE_LIST, '0, '0, '0);
    queue_cmd(cht_pkg::MODE_CLEAR, '1, '1, '1);
    queue_cmd(cht_pkg::MODE_LIST, '0, '0, '0);
    drain(200000);

    // Fill to capacity and beyond, list a full table, then clear.
    for (int i = 0; i < NODE_CNT + 2; i++)
      queue_cmd(cht_pkg::MODE_INSERT, rand64(), $urandom, rand64());
    queue_cmd(cht_pkg::MODE_LIST, '0, '0, '0);
    queue_cmd(cht_pkg::MODE_CLEAR, '0, '0, '0);
    drain(400000);

    // Random traffic with heavy receiver idling.
    queue_random(40, 55);
    drain(400000);

    // Long receiver hold-off while commands keep coming.
    send_idle_pct = 83;
    recv_idle_pct = 7;
    hold_request = 1;
    queue_random(45, 60);
    drain(400000);

    // No idling on either side.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random(40, 50);
    queue_cmd(cht_pkg::MODE_LIST, '0, '0, '0);
    drain(400000);
    repeat (300) @(posedge clk);

    $display("Checked %0d result beats: %0d lists, %0d full inserts, %0d missed removes.",
             beats_checked, lists_seen, full_seen, missing_seen);
    if (fail_count == 0 && expected_resps.size() == 0 && pending_cmds.size() == 0) begin
      $display("chained_hash_table_engine regression: pass");
    end else begin
      if (expected_resps.size() > 0)
        $display("%0t: %0d expected results never arrived", $time, expected_resps.size());
      $display("chained_hash_table_engine regression: fail");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #7_000_000;
    $display("chained_hash_table_engine regression: fail");
    $finish;
  end

endmodule
